// ----- rtl/ndb_pkg.sv -----
// ----------------------------------------------------------------------------
// ndb_pkg
// Shared types, constants and helpers for the burn-dissolve pixel core.
// ----------------------------------------------------------------------------
package ndb_pkg;

   localparam int unsigned THR_W   = 16;
   localparam int unsigned DIST_W  = 14;
   localparam int unsigned WGT_W   = 17;

   localparam logic [15:0] BAND_HOT_LIMIT    = 16'd1536;
   localparam logic [15:0] BAND_ORANGE_LIMIT = 16'd6400;
   localparam logic [15:0] BAND_OUTER_LIMIT  = 16'd12800;

   // t = floor(d * 65536 / 12800) = floor(d * 128 / 25), exact for d <= 12800
   localparam logic [21:0] T_RECIP = 22'd2684355;
   localparam int unsigned T_SHIFT = 19;

   typedef enum logic [1:0] {
      MODE_BURNT,
      MODE_PASS,
      MODE_TINT
   } mode_type;

   typedef enum logic [1:0] {
      BAND_HOT,
      BAND_ORANGE,
      BAND_DARK
   } band_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } tint_type;

   function automatic tint_type band_tint(input band_type band);
      tint_type tint;
      unique case (band)
         BAND_HOT:    tint = '{r: 8'd255, g: 8'd255, b: 8'd200};
         BAND_ORANGE: tint = '{r: 8'd255, g: 8'd120, b: 8'd0};
         BAND_DARK:   tint = '{r: 8'd120, g: 8'd40,  b: 8'd10};
         default:     tint = '{r: 8'd120, g: 8'd40,  b: 8'd10};
      endcase
      return tint;
   endfunction

   // c + floor((tint - c) * w / 65536)
   function automatic logic [7:0] blend(input logic [7:0] c, input logic [7:0] tint,
                                        input logic [WGT_W-1:0] w);
      logic signed [8:0]  diff;
      logic signed [26:0] prod;
      logic signed [10:0] corr;
      logic signed [10:0] sum;
      diff = $signed({1'b0, tint}) - $signed({1'b0, c});
      prod = diff * $signed({1'b0, w});
      corr = prod[26:16];
      sum  = $signed({3'b000, c}) + corr;
      return sum[7:0];
   endfunction

endpackage

// ----- rtl/noise_dissolve_burn_pixel_core.sv -----
// ----------------------------------------------------------------------------
// noise_dissolve_burn_pixel_core
// Burn-dissolve pixel shader: burns away, tints or passes each source pixel.
// ----------------------------------------------------------------------------
// Five-stage pipeline taking one request per clock when not stalled and returning
// one result per request, presented from the stage 5 register. Stage 1 compares
// noise against the threshold and picks the band, stage 2 forms the weight t with
// one constant multiply, stages 3 and 4 each hold one square/cube multiplier
// alongside one channel blend, stage 5 blends blue. A stall on the result side
// while a result is presented freezes the whole pipeline and raises req_stall in
// the same cycle.
// Write burn_threshold only while the pipeline is empty.
module noise_dissolve_burn_pixel_core
   import ndb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_noise_value,
   input  logic [31:0] req_source_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_pixel
);

   logic [THR_W-1:0] thr_ff;

   logic             s1_valid_ff, s1_valid_in;
   mode_type         s1_mode_ff, s1_mode_in;
   band_type         s1_band_ff, s1_band_in;
   logic [DIST_W-1:0] s1_dist_ff, s1_dist_in;
   logic [31:0]      s1_pix_ff;

   logic             s2_valid_ff;
   mode_type         s2_mode_ff;
   band_type         s2_band_ff;
   logic [WGT_W-1:0] s2_t_ff, s2_t_in;
   logic [31:0]      s2_pix_ff;

   logic             s3_valid_ff;
   mode_type         s3_mode_ff;
   band_type         s3_band_ff;
   logic [WGT_W-1:0] s3_t_ff, s3_t2_ff, s3_t2_in;
   logic [31:0]      s3_pix_ff, s3_pix_in;

   logic             s4_valid_ff;
   mode_type         s4_mode_ff;
   band_type         s4_band_ff;
   logic [WGT_W-1:0] s4_t2_ff, s4_t3_ff, s4_t3_in;
   logic [31:0]      s4_pix_ff, s4_pix_in;

   logic             out_valid_ff;
   logic [31:0]      out_pix_ff, out_pix_in;

   logic             advance;
   logic [16:0]      n16;
   logic [15:0]      edge_q;
   logic [35:0]      t_prod;
   logic [33:0]      t2_prod;
   logic [33:0]      t3_prod;
   tint_type         tint3, tint4, tint5;

   assign advance   = !(out_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_result_pixel = out_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // stage 1: threshold compare and band select
   always_comb begin
      n16         = {1'b0, req_noise_value, 8'h00};
      edge_q      = n16[15:0] - thr_ff;
      s1_valid_in = req_valid;
      s1_dist_in  = DIST_W'(BAND_OUTER_LIMIT - edge_q);
      if (n16 < {1'b0, thr_ff}) begin
         s1_mode_in = MODE_BURNT;
      end else if (edge_q >= BAND_OUTER_LIMIT) begin
         s1_mode_in = MODE_PASS;
      end else begin
         s1_mode_in = MODE_TINT;
      end
      if (edge_q < BAND_HOT_LIMIT) begin
         s1_band_in = BAND_HOT;
      end else if (edge_q < BAND_ORANGE_LIMIT) begin
         s1_band_in = BAND_ORANGE;
      end else begin
         s1_band_in = BAND_DARK;
      end
   end

   // stage 2: weight t
   always_comb begin
      t_prod  = 36'(s1_dist_ff) * 36'(T_RECIP);
      s2_t_in = t_prod[T_SHIFT +: WGT_W];
   end

   // stage 3: t squared, red blend
   always_comb begin
      t2_prod   = 34'(s2_t_ff) * 34'(s2_t_ff);
      s3_t2_in  = t2_prod[16 +: WGT_W];
      tint3     = band_tint(s2_band_ff);
      s3_pix_in = s2_pix_ff;
      if (s2_mode_ff == MODE_TINT) begin
         s3_pix_in[31:24] = blend(s2_pix_ff[31:24], tint3.r, s2_t_ff);
      end
   end

   // stage 4: t cubed, green blend
   always_comb begin
      t3_prod   = 34'(s3_t2_ff) * 34'(s3_t_ff);
      s4_t3_in  = t3_prod[16 +: WGT_W];
      tint4     = band_tint(s3_band_ff);
      s4_pix_in = s3_pix_ff;
      if (s3_mode_ff == MODE_TINT) begin
         s4_pix_in[23:16] = blend(s3_pix_ff[23:16], tint4.g, s3_t2_ff);
      end
   end

   // stage 5: blue blend and final select
   always_comb begin
      tint5 = band_tint(s4_band_ff);
      unique case (s4_mode_ff)
         MODE_BURNT: out_pix_in = '0;
         MODE_TINT: begin
            out_pix_in = s4_pix_ff;
            out_pix_in[15:8] = blend(s4_pix_ff[15:8], tint5.b, s4_t3_ff);
         end
         default:    out_pix_in = s4_pix_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mode_ff <= s1_mode_in;
         s1_band_ff <= s1_band_in;
         s1_dist_ff <= s1_dist_in;
         s1_pix_ff  <= req_source_pixel;

         s2_mode_ff <= s1_mode_ff;
         s2_band_ff <= s1_band_ff;
         s2_t_ff    <= s2_t_in;
         s2_pix_ff  <= s1_pix_ff;

         s3_mode_ff <= s2_mode_ff;
         s3_band_ff <= s2_band_ff;
         s3_t_ff    <= s2_t_ff;
         s3_t2_ff   <= s3_t2_in;
         s3_pix_ff  <= s3_pix_in;

         s4_mode_ff <= s3_mode_ff;
         s4_band_ff <= s3_band_ff;
         s4_t2_ff   <= s3_t2_ff;
         s4_t3_ff   <= s4_t3_in;
         s4_pix_ff  <= s4_pix_in;

         out_pix_ff <= out_pix_in;
      end
   end

   a_t_range: assert property (@(posedge clock) disable iff (reset)
      advance && s1_valid_ff && s1_mode_ff == MODE_TINT
      |=> s2_t_ff != '0 && s2_t_ff <= WGT_W'(65536))
      else $error("weight t out of range");

   a_t2_order: assert property (@(posedge clock) disable iff (reset)
      advance && s2_valid_ff && s2_mode_ff == MODE_TINT |=> s3_t2_ff <= s3_t_ff)
      else $error("t squared exceeds t");

   a_t3_order: assert property (@(posedge clock) disable iff (reset)
      advance && s3_valid_ff && s3_mode_ff == MODE_TINT |=> s4_t3_ff <= s4_t2_ff)
      else $error("t cubed exceeds t squared");

   a_burnt_zero: assert property (@(posedge clock) disable iff (reset)
      advance && s4_valid_ff && s4_mode_ff == MODE_BURNT
      |=> rsp_valid && rsp_result_pixel == '0)
      else $error("burnt pixel not transparent");

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the burn-dissolve pixel core. Directed requests
// cover the burnt-away case, the exact-threshold edge, every band boundary
// and the extreme thresholds. Random phases then run under several burn
// thresholds and flow-control mixes. A scoreboard predicts every result
// pixel and compares it in order.
// ----------------------------------------------------------------------------
module tb;
   import ndb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   class burn_scoreboard;
      logic [15:0] threshold;
      logic [31:0] expected_pixels[$];
      int unsigned mismatches;

      function new();
         threshold = 16'd0;
         mismatches = 0;
      endfunction

      function logic [7:0] mix_channel(logic [7:0] c, logic [7:0] tint, logic [31:0] w);
         logic [31:0] acc;
         acc = {24'd0, c} * (32'h0001_0000 - w) + {24'd0, tint} * w;
         return acc[23:16];
      endfunction

      function logic [31:0] burn_pixel(logic [7:0] noise, logic [31:0] src);
         logic [16:0] level;
         logic [16:0] gap;
         logic [31:0] t;
         logic [63:0] t2;
         logic [63:0] t3;
         band_type band;
         logic [7:0] tr;
         logic [7:0] tg;
         logic [7:0] tb;
         level = {1'b0, noise, 8'h00};
         if (level < {1'b0, threshold}) return 32'h0;
         gap = level - {1'b0, threshold};
         if (gap >= {1'b0, BAND_OUTER_LIMIT}) return src;
         if (gap < {1'b0, BAND_HOT_LIMIT}) band = BAND_HOT;
         else if (gap < {1'b0, BAND_ORANGE_LIMIT}) band = BAND_ORANGE;
         else band = BAND_DARK;
         case (band)
            BAND_HOT: begin
               tr = 8'd255; tg = 8'd255; tb = 8'd200;
            end
            BAND_ORANGE: begin
               tr = 8'd255; tg = 8'd120; tb = 8'd0;
            end
            default: begin
               tr = 8'd120; tg = 8'd40; tb = 8'd10;
            end
         endcase
         t = ({15'd0, {1'b0, BAND_OUTER_LIMIT} - gap} << 16) / {16'd0, BAND_OUTER_LIMIT};
         t2 = ({32'd0, t} * {32'd0, t}) >> 16;
         t3 = (t2 * {32'd0, t}) >> 16;
         return {mix_channel(src[31:24], tr, t),
                 mix_channel(src[23:16], tg, t2[31:0]),
                 mix_channel(src[15:8], tb, t3[31:0]),
                 src[7:0]};
      endfunction

      function void note_request(logic [7:0] noise, logic [31:0] src);
         expected_pixels.push_back(burn_pixel(noise, src));
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH: %s", what);
         mismatches++;
      endtask

      task check_result(logic [31:0] got);
         logic [31:0] want;
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("result_pixel %h with no request pending", got));
         end else begin
            want = expected_pixels.pop_front();
            if (got !== want)
               report_mismatch($sformatf("result_pixel %h, predicted %h", got, want));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_noise_value;
   logic [31:0] req_source_pixel;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_result_pixel;

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned hold_cycles;

   burn_scoreboard sb;

   noise_dissolve_burn_pixel_core DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_noise_value  (req_noise_value),
      .req_source_pixel (req_source_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_pixel (rsp_result_pixel)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2_400_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   initial begin
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_result_pixel);
      end
   end

   task automatic send_request(input logic [7:0] noise, input logic [31:0] src);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_noise_value <= noise;
      req_source_pixel <= src;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         if (taken) sb.note_request(noise, src);
         @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_threshold(input logic [15:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.threshold = value;
   endtask

   task automatic run_random(input int unsigned count, input int unsigned send_pct,
                             input int unsigned recv_pct, input bit pressure);
      int n_i;
      logic [7:0] noise;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         if (pressure && i == count / 4) hold_cycles = 80;
         if (pressure && i == (count * 2) / 3) begin
            req_valid <= 1'b0;
            while (sb.pending() != 0) @(posedge clock);
         end
         if ($urandom_range(9) < 7) begin
            n_i = int'(sb.threshold >> 8) + int'($urandom_range(53)) - 2;
            if (n_i < 0) n_i = 0;
            if (n_i > 255) n_i = 255;
            noise = n_i[7:0];
         end else begin
            noise = 8'($urandom_range(255));
         end
         send_request(noise, $urandom);
      end
   endtask

   initial begin
      sb = new();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 0;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 16'd0;
      req_valid <= 1'b0;
      req_noise_value <= 8'd0;
      req_source_pixel <= 32'd0;
      rsp_stall <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(8'd0, 32'h00FF_00FF);
      send_request(8'd52, 32'hFFFF_FFFF);

      set_threshold(16'h4000);
      send_request(8'd63, 32'hFFFF_FFFF);
      send_request(8'd64, 32'h0000_0000);
      send_request(8'd64, 32'hFFFF_FFFF);
      send_request(8'd69, 32'h1234_5678);
      send_request(8'd70, 32'h00FF_FF00);
      send_request(8'd88, 32'hFF00_00FF);
      send_request(8'd89, 32'h8080_8080);
      send_request(8'd113, 32'h0000_0000);
      send_request(8'd114, 32'hDEAD_BEEF);
      send_request(8'd255, 32'hFFFF_FFFF);
      send_request(8'd0, 32'hFFFF_FFFF);

      set_threshold(16'h4001);
      send_request(8'd64, 32'h5A5A_5A5A);
      send_request(8'd70, 32'hA5A5_A5A5);
      send_request(8'd89, 32'h0102_0304);
      send_request(8'd114, 32'hFFFF_FFFF);

      set_threshold(16'hFF00);
      send_request(8'd255, 32'h8080_8080);
      send_request(8'd254, 32'hFFFF_FFFF);

      set_threshold(16'hFFFF);
      send_request(8'd255, 32'hFFFF_FFFF);

      set_threshold(16'h0000);
      run_random(75, 0, 0, 1'b0);
      set_threshold(16'hFF00);
      run_random(75, 52, 0, 1'b0);
      set_threshold(16'hFFFF);
      run_random(75, 0, 52, 1'b0);
      set_threshold(16'($urandom_range(65535)));
      run_random(75, 23, 23, 1'b1);
      set_threshold(16'($urandom_range(65535)));
      run_random(75, 0, 0, 1'b0);
      set_threshold(16'($urandom_range(65535)));
      run_random(75, 52, 0, 1'b0);
      set_threshold(16'($urandom_range(65535)));
      run_random(75, 0, 52, 1'b0);
      set_threshold(16'($urandom_range(65535)));
      run_random(75, 23, 23, 1'b0);

      wait_idle();
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d predicted results never arrived", sb.pending()));
      if (sb.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- noise_dissolve_burn_pixel_core.f -----
rtl/ndb_pkg.sv
rtl/noise_dissolve_burn_pixel_core.sv
tb/sv/tb.sv
